// ===== src/mgas_pkg.sv =====
// ----------------------------------------------------------------------------
// mgas_pkg
// shared widths, defaults and register codes of the median gated aim setpoint
// ----------------------------------------------------------------------------
package mgas_pkg;

  localparam int DEFAULT_WINDOW = 8;
  localparam int DATA_W         = 16;
  localparam int LIMIT_W        = 15;
  localparam int CFG_DATA_W     = 15;
  localparam int CFG_IDX_W      = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_ENABLE    = 1'b0,
    CFG_POSITION_LIMIT = 1'b1
  } cfg_reg_t;

endpackage

// ===== src/mgas_if.sv =====
// ----------------------------------------------------------------------------
// mgas_in_if / mgas_out_if
// valid/ready channels carrying sample beats in and setpoint beats out
// ----------------------------------------------------------------------------
interface mgas_in_if import mgas_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     sample_valid;
  logic signed [DATA_W-1:0] target_offset;
  logic signed [DATA_W-1:0] axis_position;

  modport source (output valid, sample_valid, target_offset, axis_position,
                  input ready);
  modport sink   (input valid, sample_valid, target_offset, axis_position,
                  output ready);
endinterface

interface mgas_out_if import mgas_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] aim_setpoint;
  logic signed [DATA_W-1:0] median_offset;
  logic                     was_clamped;

  modport source (output valid, aim_setpoint, median_offset, was_clamped,
                  input ready);
  modport sink   (input valid, aim_setpoint, median_offset, was_clamped,
                  output ready);
endinterface

// ===== src/median_gated_aim_setpoint_top.sv =====
// ----------------------------------------------------------------------------
// median_gated_aim_setpoint_top
// ring window of offsets in a synchronous ram, upper median by rank counting,
// median plus axis position clamped to the configured limit
// ----------------------------------------------------------------------------
// an enabled beat starts a scan: for each candidate, a read of it and a read of every
//   entry, set by the single read port of the window ram, one compare per cycle;
//   no new beat is taken in S_SCAN, S_DRAIN or S_FIN, and S_FIN waits for a free output
// disabled beats are taken one per cycle while idle and give no result
// reset: tracking off, limit at maximum, window reads as zero, index zero
// ----------------------------------------------------------------------------
module median_gated_aim_setpoint_top
  import mgas_pkg::*;
#(
  parameter int WINDOW = DEFAULT_WINDOW
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mgas_in_if.sink               in_bus,
  mgas_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [CNT_W-1:0] RANK    = CNT_W'(WINDOW / 2);
  localparam logic [CNT_W-1:0] LAST_ST = CNT_W'(WINDOW);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(WINDOW - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic               enable_r;
  logic [LIMIT_W-1:0] limit_r;

  // window ram and entry valid bits
  logic [DATA_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0] vld_r;
  logic [IDX_W-1:0]  wr_idx_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  // scan control
  logic [IDX_W-1:0] cand_r;
  logic [CNT_W-1:0] step_r;
  logic             iss_act_r;
  logic             iss_cand_r;
  logic             iss_last_r;

  // rank counting
  logic signed [DATA_W-1:0] cand_val_r;
  logic signed [DATA_W-1:0] med_r;
  logic signed [DATA_W-1:0] data_val;
  logic [CNT_W-1:0]         lt_r, le_r, lt_nxt, le_nxt;
  logic signed [DATA_W-1:0] axis_r;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_sp_r, out_med_r;
  logic                     out_clamp_r;

  logic in_acc, take, out_free;
  logic signed [DATA_W:0] sum_w, lim_p, lim_n;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign take         = in_acc && enable_r;
  assign out_free     = !out_valid_r || out_bus.ready;

  assign out_bus.valid         = out_valid_r;
  assign out_bus.aim_setpoint  = out_sp_r;
  assign out_bus.median_offset = out_med_r;
  assign out_bus.was_clamped   = out_clamp_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_ENABLE:    enable_r <= cfg_data[0];
        CFG_POSITION_LIMIT: limit_r  <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  // window ram
  assign rd_addr = (step_r == '0) ? cand_r : IDX_W'(step_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (take && in_bus.sample_valid) begin
      mem[wr_idx_r] <= in_bus.target_offset;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wr_idx_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (cfg_we && cfg_index == CFG_AUTO_ENABLE && cfg_data[0] && !enable_r) begin
        vld_r    <= '0;
        wr_idx_r <= '0;
      end else if (take) begin
        if (in_bus.sample_valid) begin
          vld_r[wr_idx_r] <= 1'b1;
        end
        wr_idx_r <= (wr_idx_r == LAST_IX) ? '0 : wr_idx_r + IDX_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (take) state_nxt = S_SCAN;
      S_SCAN:  if (step_r == LAST_ST && cand_r == LAST_IX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cand_r     <= '0;
      step_r     <= '0;
      iss_act_r  <= 1'b0;
      iss_cand_r <= 1'b0;
      iss_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_act_r  <= (state_r == S_SCAN);
      iss_cand_r <= (step_r == '0);
      iss_last_r <= (step_r == LAST_ST);
      if (state_r == S_SCAN) begin
        if (step_r == LAST_ST) begin
          step_r <= '0;
          cand_r <= (cand_r == LAST_IX) ? '0 : cand_r + IDX_W'(1);
        end else begin
          step_r <= step_r + CNT_W'(1);
        end
      end else begin
        step_r <= '0;
        cand_r <= '0;
      end
    end
  end

  // rank counting on returned reads
  assign data_val = rd_vld_r ? $signed(rd_data_r) : '0;
  assign lt_nxt   = lt_r + CNT_W'(data_val <  cand_val_r);
  assign le_nxt   = le_r + CNT_W'(data_val <= cand_val_r);

  always_ff @(posedge clk) begin
    if (take) begin
      axis_r <= in_bus.axis_position;
    end
    if (iss_act_r) begin
      if (iss_cand_r) begin
        cand_val_r <= data_val;
        lt_r       <= '0;
        le_r       <= '0;
      end else begin
        lt_r <= lt_nxt;
        le_r <= le_nxt;
        if (iss_last_r && lt_nxt <= RANK && le_nxt > RANK) begin
          med_r <= cand_val_r;
        end
      end
    end
  end

  // sum and clamp
  assign sum_w = {axis_r[DATA_W-1], axis_r} + {med_r[DATA_W-1], med_r};
  assign lim_p = $signed({2'b00, limit_r});
  assign lim_n = -lim_p;

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_med_r <= med_r;
      if (sum_w > lim_p) begin
        out_sp_r    <= lim_p[DATA_W-1:0];
        out_clamp_r <= 1'b1;
      end else if (sum_w < lim_n) begin
        out_sp_r    <= lim_n[DATA_W-1:0];
        out_clamp_r <= 1'b1;
      end else begin
        out_sp_r    <= sum_w[DATA_W-1:0];
        out_clamp_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== src/mgas_checker.sv =====
// ----------------------------------------------------------------------------
// mgas_props
// port level checks of the median gated aim setpoint, bound to the top level
// ----------------------------------------------------------------------------
module mgas_props
  import mgas_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] aim_setpoint,
  input logic                     was_clamped,
  input logic                     cfg_we,
  input cfg_reg_t                 cfg_index,
  input logic [CFG_DATA_W-1:0]    cfg_data
);

  logic               en_r;
  logic [LIMIT_W-1:0] lim_r;
  logic signed [DATA_W:0] lim_p, lim_n, sp_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b0;
      lim_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_ENABLE:    en_r  <= cfg_data[0];
        CFG_POSITION_LIMIT: lim_r <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  assign lim_p = $signed({2'b00, lim_r});
  assign lim_n = -lim_p;
  assign sp_w  = {aim_setpoint[DATA_W-1], aim_setpoint};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(aim_setpoint))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sp_w <= lim_p && sp_w >= lim_n)
    else $error("setpoint outside limit");

  a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && was_clamped |-> sp_w == lim_p || sp_w == lim_n)
    else $error("clamped setpoint not at limit");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && en_r |=> !in_ready)
    else $error("enabled beat did not start median scan");

endmodule

bind median_gated_aim_setpoint_top mgas_props u_mgas_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .aim_setpoint (out_bus.aim_setpoint),
  .was_clamped  (out_bus.was_clamped),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);
